// ----- rtl/pai_pkg.sv -----
// Shared types and constants for the positional array insert/delete block.
// No dependencies; imported by every module of the block.
package pai_pkg;

   localparam int DEPTH   = 64;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int DATA_W  = 32;
   localparam int FUNC_W  = 2;
   localparam int POS_W   = 7;
   localparam int STAT_W  = 2;
   localparam int EIDX_W  = 6;
   localparam int COUNT_W = 7;

   localparam logic [FUNC_W-1:0] FUNC_INSERT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TRAVERSE = 2'd2;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_BADPOS = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic [IDX_W-1:0]        pos;
      logic [IDX_W-1:0]        last_idx;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

// ----- rtl/positional_array_insert_delete.sv -----
// Positional array insert/delete: a chain of entry cells under one controller.
// Depends on pai_pkg, pai_cell and pai_ctrl.
//
// Usage:
//   Request channel (req_*): func 0 inserts req_value at req_position,
//   func 1 deletes the entry at req_position, func 2 traverses the array,
//   func 3 is dropped without a response.
//   Response channel (rsp_*): insert and delete return one beat with status,
//   count and rsp_last set. Traverse returns one beat per stored entry in
//   order, rsp_last on the final one, and no beat when the array is empty.
//   The response beat of an insert or delete is registered at the edge that
//   takes the request beat; the first traverse beat is registered from the
//   traverse state, which the controller enters on taking the request.
//   Insert and delete act on the whole chain at once, as every cell shifts in
//   parallel; a traverse first enters the traverse state, then the chain
//   rotates one place per beat and ends back in its original order.
//   One request is in work at a time; a new request is taken once the
//   controller is idle and the response register is empty or being drained.
//   Reset clears the length to zero; entry contents are not cleared.
//   When the receiver stalls, the response register holds and the chain waits.
module positional_array_insert_delete
   import pai_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DATA_W-1:0]  req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STAT_W-1:0]         rsp_status,
   output logic signed [DATA_W-1:0]  rsp_entry,
   output logic [EIDX_W-1:0]         rsp_entry_index,
   output logic [COUNT_W-1:0]        rsp_count,
   output logic                      rsp_last
);

   cell_cmd_type             cmd;
   logic signed [DATA_W-1:0] cell_q [DEPTH];

   pai_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_position    (req_position),
      .req_value       (req_value),
      .head_entry      (cell_q[0]),
      .cmd             (cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_entry       (rsp_entry),
      .rsp_entry_index (rsp_entry_index),
      .rsp_count       (rsp_count),
      .rsp_last        (rsp_last)
   );

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [DATA_W-1:0] left_entry;
      logic signed [DATA_W-1:0] right_entry;

      if (g == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_mid_l
         assign left_entry = cell_q[g-1];
      end

      if (g == DEPTH - 1) begin : g_end
         assign right_entry = '0;
      end else begin : g_mid_r
         assign right_entry = cell_q[g+1];
      end

      pai_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_W'(g)),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .head_entry  (cell_q[0]),
         .entry_q     (cell_q[g])
      );
   end

endmodule

// ----- rtl/pai_cell.sv -----
// One storage cell of the array chain: holds one entry, loads from a neighbor, the head cell or the request value.
// Depends on pai_pkg.
module pai_cell
   import pai_pkg::*;
(
   input  logic                     clock,
   input  logic [IDX_W-1:0]         cell_index,
   input  cell_cmd_type             cmd,
   input  logic signed [DATA_W-1:0] left_entry,
   input  logic signed [DATA_W-1:0] right_entry,
   input  logic signed [DATA_W-1:0] head_entry,
   output logic signed [DATA_W-1:0] entry_q
);

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (cell_index == cmd.pos) begin
               entry_in = cmd.value;
            end else if (cell_index > cmd.pos) begin
               entry_in = left_entry;
            end
         end
         CELL_DELETE: begin
            if (cell_index >= cmd.pos) begin
               entry_in = right_entry;
            end
         end
         CELL_ROTATE: begin
            if (cell_index < cmd.last_idx) begin
               entry_in = right_entry;
            end else if (cell_index == cmd.last_idx) begin
               entry_in = head_entry;
            end
         end
         CELL_HOLD: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

// ----- rtl/pai_ctrl.sv -----
// Control for the array chain: operation decode, length, traverse sequencing
// and the response register. Depends on pai_pkg.
module pai_ctrl
   import pai_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DATA_W-1:0]  req_value,
   input  logic signed [DATA_W-1:0]  head_entry,
   output cell_cmd_type              cmd,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STAT_W-1:0]         rsp_status,
   output logic signed [DATA_W-1:0]  rsp_entry,
   output logic [EIDX_W-1:0]         rsp_entry_index,
   output logic [COUNT_W-1:0]        rsp_count,
   output logic                      rsp_last
);

   typedef enum logic {
      ST_IDLE,
      ST_TRAV
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         trav_ff, trav_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               status_ff, status_in;
   logic signed [DATA_W-1:0] entry_ff, entry_in;
   logic [IDX_W-1:0]         eidx_ff, eidx_in;
   logic                     last_ff, last_in;

   logic             slot_free;
   logic             accept;
   logic             emit;
   logic [POS_W-1:0] count_pos;
   logic             trav_last;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign accept    = req_valid && req_ready;
   assign count_pos = POS_W'(count_ff);
   assign trav_last = (CNT_W'(trav_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      trav_in      = trav_ff;
      status_in    = status_ff;
      entry_in     = entry_ff;
      eidx_in      = eidx_ff;
      last_in      = last_ff;
      emit         = 1'b0;
      cmd.op       = CELL_HOLD;
      cmd.pos      = IDX_W'(req_position);
      cmd.last_idx = IDX_W'(count_ff - CNT_W'(1));
      cmd.value    = req_value;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               entry_in = '0;
               eidx_in  = '0;
               last_in  = 1'b1;
               unique case (req_func)
                  FUNC_INSERT: begin
                     emit = 1'b1;
                     if (count_ff == CNT_W'(DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else if (req_position > count_pos) begin
                        status_in = STATUS_BADPOS;
                     end else begin
                        status_in = STATUS_OK;
                        cmd.op    = CELL_INSERT;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_DELETE: begin
                     emit = 1'b1;
                     if (req_position >= count_pos) begin
                        status_in = STATUS_BADPOS;
                     end else begin
                        status_in = STATUS_OK;
                        cmd.op    = CELL_DELETE;
                        count_in  = count_ff - CNT_W'(1);
                     end
                  end
                  FUNC_TRAVERSE: begin
                     if (count_ff != '0) begin
                        state_in = ST_TRAV;
                        trav_in  = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TRAV: begin
            if (slot_free) begin
               emit      = 1'b1;
               cmd.op    = CELL_ROTATE;
               status_in = STATUS_OK;
               entry_in  = head_entry;
               eidx_in   = trav_ff;
               last_in   = trav_last;
               trav_in   = trav_ff + IDX_W'(1);
               if (trav_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         trav_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         trav_ff      <= trav_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      entry_ff  <= entry_in;
      eidx_ff   <= eidx_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry       = entry_ff;
   assign rsp_entry_index = EIDX_W'(eidx_ff);
   assign rsp_count       = COUNT_W'(count_ff);
   assign rsp_last        = last_ff;

endmodule

// ----- rtl/pai_checker.sv -----
// Port-level checks for the positional array insert/delete block, and the bind
// that attaches them to the top level. Depends on pai_pkg.
module pai_checker
   import pai_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [STAT_W-1:0]        rsp_status,
   input logic signed [DATA_W-1:0] rsp_entry,
   input logic [EIDX_W-1:0]        rsp_entry_index,
   input logic [COUNT_W-1:0]       rsp_count,
   input logic                     rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry) && $stable(rsp_last))
      else $error("response beat changed while stalled");

   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_last && (rsp_entry == '0)
         && (rsp_entry_index == '0))
      else $error("failed operation beat is not a single zero beat");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> rsp_count == COUNT_W'(DEPTH))
      else $error("full status with array not full");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= COUNT_W'(DEPTH))
      else $error("count beyond depth");

endmodule

bind positional_array_insert_delete pai_checker u_pai_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_entry       (rsp_entry),
   .rsp_entry_index (rsp_entry_index),
   .rsp_count       (rsp_count),
   .rsp_last        (rsp_last)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for positional_array_insert_delete: a queue-fed driver, a response monitor and a
// shadow array that predicts every beat of insert, delete and traverse requests.
// Depends on pai_pkg and the positional_array_insert_delete RTL.
module testbench;
   import pai_pkg::*;

   localparam int CLK_PERIOD = 12;
   localparam int TIMEOUT_CYCLES = 400_000;
   localparam int RANDOM_ITEMS = 250;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [FUNC_W-1:0]        func;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } request_type;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] entry;
      logic [EIDX_W-1:0]        entry_index;
      logic [COUNT_W-1:0]       count;
      logic                     last;
   } response_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FUNC_W-1:0]        req_func = FUNC_INSERT;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b1;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0] rsp_entry;
   logic [EIDX_W-1:0]        rsp_entry_index;
   logic [COUNT_W-1:0]       rsp_count;
   logic                     rsp_last;

   request_type  pending_requests[$];
   response_type expected_rsp[$];

   // shadow of the array, updated as each request beat is taken
   logic signed [DATA_W-1:0] shadow_mem [DEPTH];
   int shadow_len = 0;

   // length as the stimulus generator expects it once all queued requests are applied
   int planned_len = 0;
   int planned_items = 0;

   int mismatches = 0;
   int requests_taken = 0;
   bit req_fire = 1'b0;

   int burst_left = 8;
   int gap_left = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   int stall_mode = 0;
   int mode_left = 0;
   int phase = 0;

   positional_array_insert_delete dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_entry       (rsp_entry),
      .rsp_entry_index (rsp_entry_index),
      .rsp_count       (rsp_count),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("tb: failure");
      $finish;
   end

   function automatic logic [POS_W-1:0] rand_position(input int lo, input int hi);
      int unsigned r;
      r = $urandom_range(hi, lo);
      return r[POS_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_value();
      logic [DATA_W-1:0] r;
      case ($urandom_range(0, 7))
         0: r = 32'h8000_0000;
         1: r = 32'h7FFF_FFFF;
         2: r = 32'hFFFF_FFFF;
         default: r = $urandom;
      endcase
      return r;
   endfunction

   // computes the response beats of one request and applies it to the shadow array
   function automatic void apply_request(input request_type rq);
      response_type rs;
      int p;
      p = int'(rq.position);
      rs.status = STATUS_OK;
      rs.entry = '0;
      rs.entry_index = '0;
      rs.last = 1'b1;
      case (rq.func)
         FUNC_INSERT: begin
            if (shadow_len == DEPTH) begin
               rs.status = STATUS_FULL;
            end else if (p > shadow_len) begin
               rs.status = STATUS_BADPOS;
            end else begin
               for (int i = shadow_len; i > p; i--) shadow_mem[i] = shadow_mem[i-1];
               shadow_mem[p] = rq.value;
               shadow_len++;
            end
            rs.count = shadow_len[COUNT_W-1:0];
            expected_rsp.push_back(rs);
         end
         FUNC_DELETE: begin
            if (p >= shadow_len) begin
               rs.status = STATUS_BADPOS;
            end else begin
               for (int i = p; i + 1 < shadow_len; i++) shadow_mem[i] = shadow_mem[i+1];
               shadow_len--;
            end
            rs.count = shadow_len[COUNT_W-1:0];
            expected_rsp.push_back(rs);
         end
         FUNC_TRAVERSE: begin
            for (int i = 0; i < shadow_len; i++) begin
               rs.entry = shadow_mem[i];
               rs.entry_index = i[EIDX_W-1:0];
               rs.count = shadow_len[COUNT_W-1:0];
               rs.last = (i + 1 == shadow_len);
               expected_rsp.push_back(rs);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [DATA_W-1:0] got,
                                       input logic [DATA_W-1:0] want);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic queue_request(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] position,
                                input logic signed [DATA_W-1:0] value);
      request_type rq;
      int p;
      rq.func = func;
      rq.position = position;
      rq.value = value;
      pending_requests.push_back(rq);
      p = int'(position);
      if (func == FUNC_INSERT && planned_len < DEPTH && p <= planned_len) planned_len++;
      if (func == FUNC_DELETE && p < planned_len) planned_len--;
      if (func != FUNC_UNUSED) planned_items++;
   endtask

   // one random request; insert_pct steers growth of the array
   task automatic queue_random(input int insert_pct);
      int roll;
      logic [POS_W-1:0] p;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         queue_request(FUNC_UNUSED, rand_position(0, 127), rand_value());
      end else if (roll < 8) begin
         queue_request(FUNC_TRAVERSE, rand_position(0, 127), rand_value());
      end else if (roll < 12) begin
         if ($urandom_range(0, 1) == 0)
            queue_request(FUNC_INSERT, rand_position(planned_len + 1, 127), rand_value());
         else
            queue_request(FUNC_DELETE, rand_position(planned_len, 127), rand_value());
      end else if ($urandom_range(0, 99) < insert_pct || planned_len == 0) begin
         case ($urandom_range(0, 3))
            0: p = '0;
            1: p = rand_position(planned_len, planned_len);
            default: p = rand_position(0, planned_len);
         endcase
         queue_request(FUNC_INSERT, p, rand_value());
      end else begin
         case ($urandom_range(0, 3))
            0: p = '0;
            1: p = rand_position(planned_len - 1, planned_len - 1);
            default: p = rand_position(0, planned_len - 1);
         endcase
         queue_request(FUNC_DELETE, p, rand_value());
      end
   endtask

   // request driver: bursts with random gaps, payload held until the beat is taken
   always @(negedge clock) begin
      request_type rq;
      if (!reset && !(req_valid && !req_fire)) begin
         if (gap_left > 0 || pending_requests.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            rq = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_func <= rq.func;
            req_position <= rq.position;
            req_value <= rq.value;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end
         end
      end
   end

   // response receiver: changing stall pattern plus one long hold-off
   always @(negedge clock) begin
      if (!long_hold_done && requests_taken >= 40) begin
         long_hold_done = 1'b1;
         hold_left = 200;
      end
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(16, 96);
      end else begin
         mode_left--;
      end
      phase++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 1) == 0);
            default: rsp_ready <= (phase % 3 == 0);
         endcase
      end
   end

   // monitor: check response beats, then predict from the request beat
   always @(posedge clock) begin
      response_type rs;
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         req_fire = req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected beat: expected none, actual status %0d entry %0h count %0d",
                        $time, rsp_status, rsp_entry, rsp_count);
               mismatches++;
            end else begin
               rs = expected_rsp.pop_front();
               check_field("status", rsp_status, rs.status);
               check_field("entry", rsp_entry, rs.entry);
               check_field("entry_index", rsp_entry_index, rs.entry_index);
               check_field("count", rsp_count, rs.count);
               check_field("last", rsp_last, rs.last);
            end
         end
         if (req_fire) begin
            requests_taken++;
            apply_request('{req_func, req_position, req_value});
         end
      end
   end

   initial begin
      // empty array, bad positions, unused code
      queue_request(FUNC_TRAVERSE, 7'd0, 32'sd0);
      queue_request(FUNC_DELETE, 7'd0, 32'sd0);
      queue_request(FUNC_INSERT, 7'd1, 32'sd5);
      queue_request(FUNC_INSERT, 7'd127, -32'sd1);
      queue_request(FUNC_UNUSED, 7'd0, 32'sd9);
      // inserts at front, end and middle with extreme values
      queue_request(FUNC_INSERT, 7'd0, 32'sh8000_0000);
      queue_request(FUNC_INSERT, 7'd1, 32'sh7FFF_FFFF);
      queue_request(FUNC_INSERT, 7'd0, -32'sd1);
      queue_request(FUNC_INSERT, 7'd1, 32'sd0);
      queue_request(FUNC_INSERT, 7'd4, 32'sh5555_5555);
      queue_request(FUNC_INSERT, 7'd6, 32'sh2AAA_AAAA);
      queue_request(FUNC_TRAVERSE, 7'd127, 32'sd0);
      queue_request(FUNC_DELETE, 7'd5, 32'sd0);
      queue_request(FUNC_DELETE, 7'd127, 32'sd0);
      queue_request(FUNC_DELETE, 7'd2, 32'sd0);
      queue_request(FUNC_DELETE, 7'd0, 32'sd0);
      queue_request(FUNC_DELETE, 7'd2, 32'sd0);
      queue_request(FUNC_TRAVERSE, 7'd0, 32'sd0);
      queue_request(FUNC_UNUSED, 7'd127, -32'sd1);
      queue_request(FUNC_DELETE, 7'd1, 32'sd0);
      queue_request(FUNC_TRAVERSE, 7'd0, 32'sd0);
      queue_request(FUNC_DELETE, 7'd0, 32'sd0);
      queue_request(FUNC_TRAVERSE, 7'd0, 32'sd0);

      planned_items = 0;
      while (planned_len < DEPTH) queue_random(85);
      // full array: full takes priority over a bad position
      repeat (4) queue_request(FUNC_INSERT, rand_position(0, 127), rand_value());
      queue_request(FUNC_TRAVERSE, 7'd0, 32'sd0);
      queue_request(FUNC_INSERT, 7'd127, rand_value());
      queue_request(FUNC_DELETE, 7'd64, rand_value());
      queue_request(FUNC_DELETE, 7'd63, rand_value());
      queue_request(FUNC_INSERT, 7'd63, rand_value());
      queue_request(FUNC_TRAVERSE, 7'd0, 32'sd0);
      while (planned_len > 4) queue_random(20);
      while (planned_items < RANDOM_ITEMS) queue_random(55);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
